FILE: rtl/core/abt_pkg.sv
// ----------------------------------------------------------------------------
// abt_pkg
// Shared types and constants of the six-axis alpha-beta tracker.
// ----------------------------------------------------------------------------
package abt_pkg;

    // Fixed field widths of the stream words and the configuration port.
    localparam int AXIS_W      = 3;
    localparam int GAIN_W      = 17;
    localparam int CFG_IDX_W   = 1;
    localparam int IN_USER_W   = 1 + AXIS_W;
    localparam int OUT_USER_W  = AXIS_W + 1;

    // Axes below this index are linear (x, y, z); the rest are angles.
    localparam int LINEAR_AXES = 3;

    // Gain register reset values, unsigned Q0.16.
    localparam int ALPHA_RESET = 32768;
    localparam int BETA_RESET  = 16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ALPHA = 1'b0,
        REG_BETA  = 1'b1
    } cfg_reg_t;

    // Control tag that travels with every word through the pipeline.
    typedef struct packed {
        logic              upd;   // measurement for an axis in range
        logic              seed;  // axis was unprimed: measurement seeds it
        logic [AXIS_W-1:0] axis;
    } tag_t;

endpackage

FILE: rtl/core/abt_ram.sv
// ----------------------------------------------------------------------------
// abt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module abt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 6
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/six_axis_alpha_beta_tracker_unit.sv
// An accepted word passes the pipeline stages, the write-back stage and the output
// register before its result appears. Throughput: one word per cycle unless the output
// stalls; a primed update of an axis waits until the previous update of that same axis
// has been written back, as position and velocity live in RAMs read at acceptance and
// written late. Reset clears the pipeline, the primed bits and the gains to 0.5 and
// 0.25; the position and velocity RAMs are not cleared, seeding writes them first.
// ----------------------------------------------------------------------------
// six_axis_alpha_beta_tracker_unit
// Alpha-beta tracker over six pose axes with per-axis state kept in RAM.
// ----------------------------------------------------------------------------
module six_axis_alpha_beta_tracker_unit
    import abt_pkg::*;
#(
    parameter int AXES       = 6,
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // configuration write port
    input  logic                                    cfg_we,
    input  logic [CFG_IDX_W-1:0]                    cfg_index,
    input  logic [GAIN_W-1:0]                       cfg_data,
    // input stream
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [((DATA_WIDTH+7)/8)*8-1:0]         s_tdata,   // measured
    input  logic [IN_USER_W-1:0]                    s_tuser,   // cmd, axis
    // output stream
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [((3*DATA_WIDTH+7)/8)*8-1:0]       m_tdata,   // corrected, velocity, predicted
    output logic [OUT_USER_W-1:0]                   m_tuser    // axis_out, ready_res
);

    localparam int AW      = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int NSTG    = 5;                          // stages up to write-back
    localparam int SW      = DATA_WIDTH + 3;             // saturating sum width
    localparam int QW      = DATA_WIDTH + 2;             // rounded gain product
    localparam int GW      = FRAC_BITS + 1;              // clamped gain
    localparam int PW      = DATA_WIDTH + FRAC_BITS + 2; // full product
    localparam int CMP_W   = (GAIN_W > GW) ? GAIN_W : GW;
    localparam int ONE_I   = 1 << FRAC_BITS;
    localparam int ALPHA_I = (ALPHA_RESET > ONE_I) ? ONE_I : ALPHA_RESET;
    localparam int BETA_I  = (BETA_RESET > ONE_I) ? ONE_I : BETA_RESET;
    localparam int OUT_W   = ((3*DATA_WIDTH+7)/8)*8;

    localparam logic signed [SW-1:0] SMAX = {{4{1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = {{4{1'b1}}, {(DATA_WIDTH-1){1'b0}}};
    localparam logic signed [PW-1:0] HALF    = PW'(1) << (FRAC_BITS - 1);
    localparam logic signed [PW-1:0] HALF_M1 = HALF - PW'(1);

    function automatic logic signed [DATA_WIDTH-1:0] sat_d(input logic signed [SW-1:0] v);
        logic signed [DATA_WIDTH-1:0] r;
        if (v > SMAX)
        begin
            r = SMAX[DATA_WIDTH-1:0];
        end
        else if (v < SMIN)
        begin
            r = SMIN[DATA_WIDTH-1:0];
        end
        else
        begin
            r = v[DATA_WIDTH-1:0];
        end
        return r;
    endfunction

    function automatic logic [GW-1:0] clamp_gain(input logic [GAIN_W-1:0] g);
        logic [CMP_W-1:0] ge;
        logic [GW-1:0]    r;
        ge = CMP_W'(g);
        if (ge > CMP_W'(ONE_I))
        begin
            r = GW'(ONE_I);
        end
        else
        begin
            r = GW'(ge);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Configuration: gains are stored already clamped to one.
    // ------------------------------------------------------------------
    logic [GW-1:0] alpha_reg;
    logic [GW-1:0] beta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= GW'(ALPHA_I);
            beta_reg  <= GW'(BETA_I);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ALPHA: alpha_reg <= clamp_gain(cfg_data);
                REG_BETA:  beta_reg  <= clamp_gain(cfg_data);
                default:   alpha_reg <= alpha_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input decode, primed bits and read interlock
    // ------------------------------------------------------------------
    logic                         in_cmd;
    logic [AXIS_W-1:0]            in_axis;
    logic signed [DATA_WIDTH-1:0] in_meas;
    logic [AW-1:0]                in_addr;
    logic                         in_range;
    logic                         in_upd;
    logic                         in_primed;
    logic                         hazard;
    logic                         accept;
    logic [AXES-1:0]              primed_reg;

    logic [NSTG-1:0]              v_reg;
    tag_t                         tag_reg  [NSTG];
    logic signed [DATA_WIDTH-1:0] meas_reg [NSTG];
    logic [NSTG-1:0]              take;
    logic                         take6;
    logic                         take_out;

    assign in_cmd    = s_tuser[0];
    assign in_axis   = s_tuser[AXIS_W:1];
    assign in_meas   = s_tdata[DATA_WIDTH-1:0];
    assign in_addr   = AW'(in_axis);
    assign in_range  = (32'(in_axis) < AXES);
    assign in_upd    = !in_cmd && in_range;
    assign in_primed = in_range && primed_reg[in_addr];

    // A primed update reads the RAMs now; any older update of the same axis
    // that has not been written back yet would be missed.
    always_comb
    begin
        hazard = 1'b0;
        for (int k = 0; k < NSTG; k++)
        begin
            if (v_reg[k] && tag_reg[k].upd && tag_reg[k].axis == in_axis)
            begin
                hazard = 1'b1;
            end
        end
        hazard = hazard && in_upd && in_primed;
    end

    assign s_tready = take[0] && !hazard;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg <= '0;
        end
        else if (accept)
        begin
            if (in_cmd)
            begin
                primed_reg <= '0;
            end
            else if (in_range)
            begin
                primed_reg[in_addr] <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow: a stage moves when the next one is empty or moving.
    // ------------------------------------------------------------------
    logic s6_v_reg;
    logic out_v_reg;

    assign take_out = !out_v_reg || m_tready;
    assign take6    = !s6_v_reg || take_out;

    always_comb
    begin
        take[NSTG-1] = !v_reg[NSTG-1] || take6;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            take[k] = !v_reg[k] || take[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg     <= '0;
            s6_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (take[0])
            begin
                v_reg[0] <= accept;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (take[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
            if (take6)
            begin
                s6_v_reg <= v_reg[NSTG-1];
            end
            if (take_out)
            begin
                out_v_reg <= s6_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take[0])
        begin
            tag_reg[0]  <= '{upd: in_upd, seed: !in_primed, axis: in_axis};
            meas_reg[0] <= in_meas;
        end
        for (int k = 1; k < NSTG; k++)
        begin
            if (take[k])
            begin
                tag_reg[k]  <= tag_reg[k-1];
                meas_reg[k] <= meas_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // State RAMs
    // ------------------------------------------------------------------
    logic                         ram_re;
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic signed [DATA_WIDTH-1:0] rd_pos;
    logic signed [DATA_WIDTH-1:0] rd_vel;
    logic signed [DATA_WIDTH-1:0] pos_next;
    logic signed [DATA_WIDTH-1:0] vel_next;

    assign ram_re    = accept && in_upd && in_primed;
    assign ram_we    = v_reg[NSTG-1] && tag_reg[NSTG-1].upd && take6;
    assign ram_waddr = AW'(tag_reg[NSTG-1].axis);

    abt_ram #(.WIDTH(DATA_WIDTH), .DEPTH(AXES)) u_pos_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (pos_next),
        .re    (ram_re),
        .raddr (in_addr),
        .rdata (rd_pos)
    );

    abt_ram #(.WIDTH(DATA_WIDTH), .DEPTH(AXES)) u_vel_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (vel_next),
        .re    (ram_re),
        .raddr (in_addr),
        .rdata (rd_vel)
    );

    // ------------------------------------------------------------------
    // Datapath: prediction, residual, gain products, rounding, update
    // ------------------------------------------------------------------
    logic signed [DATA_WIDTH-1:0] s2_pred_reg;
    logic signed [DATA_WIDTH-1:0] s2_vel_reg;
    logic signed [DATA_WIDTH-1:0] s3_pred_reg;
    logic signed [DATA_WIDTH-1:0] s3_vel_reg;
    logic signed [DATA_WIDTH-1:0] s3_resid_reg;
    logic signed [DATA_WIDTH-1:0] s4_pred_reg;
    logic signed [DATA_WIDTH-1:0] s4_vel_reg;
    logic signed [PW-1:0]         s4_pa_reg;
    logic signed [PW-1:0]         s4_pb_reg;
    logic signed [DATA_WIDTH-1:0] s5_pred_reg;
    logic signed [DATA_WIDTH-1:0] s5_vel_reg;
    logic signed [QW-1:0]         s5_qa_reg;
    logic signed [QW-1:0]         s5_qb_reg;
    logic signed [PW-1:0]         ra_sum;
    logic signed [PW-1:0]         rb_sum;
    logic signed [DATA_WIDTH-1:0] s6_pos_reg;
    logic signed [DATA_WIDTH-1:0] s6_vel_reg;
    tag_t                         s6_tag_reg;
    logic signed [DATA_WIDTH-1:0] pred_out_next;
    logic signed [DATA_WIDTH-1:0] out_corr_reg;
    logic signed [DATA_WIDTH-1:0] out_vel_reg;
    logic signed [DATA_WIDTH-1:0] out_pred_reg;
    logic [AXIS_W-1:0]            out_axis_reg;
    logic                         out_ready_reg;

    // Ties round away from zero: a negative product adds one less than half.
    assign ra_sum = s4_pa_reg + (s4_pa_reg[PW-1] ? HALF_M1 : HALF);
    assign rb_sum = s4_pb_reg + (s4_pb_reg[PW-1] ? HALF_M1 : HALF);

    always_comb
    begin
        if (!tag_reg[NSTG-1].upd)
        begin
            pos_next = '0;
            vel_next = '0;
        end
        else if (tag_reg[NSTG-1].seed)
        begin
            pos_next = meas_reg[NSTG-1];
            vel_next = '0;
        end
        else
        begin
            pos_next = sat_d(SW'(s5_pred_reg) + SW'(s5_qa_reg));
            vel_next = sat_d(SW'(s5_vel_reg) + SW'(s5_qb_reg));
        end
    end

    always_comb
    begin
        if (32'(s6_tag_reg.axis) < LINEAR_AXES)
        begin
            pred_out_next = sat_d(SW'(s6_pos_reg) + SW'(s6_vel_reg));
        end
        else
        begin
            pred_out_next = s6_pos_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take[1])
        begin
            s2_pred_reg <= sat_d(SW'(rd_pos) + SW'(rd_vel));
            s2_vel_reg  <= rd_vel;
        end
        if (take[2])
        begin
            s3_pred_reg  <= s2_pred_reg;
            s3_vel_reg   <= s2_vel_reg;
            s3_resid_reg <= sat_d(SW'(meas_reg[1]) - SW'(s2_pred_reg));
        end
        if (take[3])
        begin
            s4_pred_reg <= s3_pred_reg;
            s4_vel_reg  <= s3_vel_reg;
            s4_pa_reg   <= s3_resid_reg * $signed({1'b0, alpha_reg});
            s4_pb_reg   <= s3_resid_reg * $signed({1'b0, beta_reg});
        end
        if (take[4])
        begin
            s5_pred_reg <= s4_pred_reg;
            s5_vel_reg  <= s4_vel_reg;
            s5_qa_reg   <= ra_sum[FRAC_BITS +: QW];
            s5_qb_reg   <= rb_sum[FRAC_BITS +: QW];
        end
        if (take6)
        begin
            s6_pos_reg <= pos_next;
            s6_vel_reg <= vel_next;
            s6_tag_reg <= tag_reg[NSTG-1];
        end
        if (take_out)
        begin
            out_corr_reg  <= s6_pos_reg;
            out_vel_reg   <= s6_vel_reg;
            out_pred_reg  <= pred_out_next;
            out_axis_reg  <= s6_tag_reg.axis;
            out_ready_reg <= s6_tag_reg.upd;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = OUT_W'({out_pred_reg, out_vel_reg, out_corr_reg});
    assign m_tuser  = {out_ready_reg, out_axis_reg};

`ifndef NO_ASSERTIONS
    // A reset command leaves every axis unprimed.
    a_cmd_unprimes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_cmd) |=> (primed_reg == '0))
        else $error("primed bits not cleared by reset command");

    // The interlock keeps a state read away from a write-back of its axis.
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> !(ram_we && ram_waddr == in_addr))
        else $error("state read collides with write-back of the same axis");

    // A word that did not update an axis carries zero estimates.
    a_idle_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !out_ready_reg) |->
            (out_corr_reg == '0 && out_vel_reg == '0 && out_pred_reg == '0))
        else $error("non-update result carries nonzero estimates");

    // Only an axis in range can report an update result as ready.
    a_ready_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && out_ready_reg) |-> (32'(out_axis_reg) < AXES))
        else $error("ready result for an axis out of range");
`endif

endmodule
